### rtl/cale_pkg.sv
package cale_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 4;
    localparam int VAL_W          = 32;
    localparam int POS_W          = 5;

    localparam logic [POS_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 4'd0,
        CMD_INSERT = 4'd1,
        CMD_APPEND = 4'd2,
        CMD_REMOVE = 4'd3,
        CMD_START  = 4'd4,
        CMD_END    = 4'd5,
        CMD_PREV   = 4'd6,
        CMD_NEXT   = 4'd7,
        CMD_MOVE   = 4'd8,
        CMD_SWAP   = 4'd9,
        CMD_READ   = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ITEM,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_SWAP_A,
        CELL_SWAP_B
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     scan_load;
        logic     scan_shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_EXEC
    } state_t;

endpackage

### rtl/cale_cell.sv
module cale_cell #(
    parameter int W = cale_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  cale_pkg::cell_ctrl_t ctrl,
    input  logic [W-1:0]         item,
    input  logic [W-1:0]         swap_a,
    input  logic [W-1:0]         swap_b,
    input  logic [W-1:0]         left_val,
    input  logic [W-1:0]         right_val,
    input  logic [W-1:0]         scan_in,
    output logic [W-1:0]         entry,
    output logic [W-1:0]         scan_out
);

    logic [W-1:0] entry_reg;
    logic [W-1:0] entry_next;
    logic [W-1:0] scan_reg;
    logic [W-1:0] scan_next;

    always_comb
    begin
        case (ctrl.op)
            cale_pkg::CELL_HOLD:   entry_next = entry_reg;
            cale_pkg::CELL_ITEM:   entry_next = item;
            cale_pkg::CELL_LEFT:   entry_next = left_val;
            cale_pkg::CELL_RIGHT:  entry_next = right_val;
            cale_pkg::CELL_SWAP_A: entry_next = swap_a;
            cale_pkg::CELL_SWAP_B: entry_next = swap_b;
            default:               entry_next = entry_reg;
        endcase
    end

    always_comb
    begin
        if (ctrl.scan_load)
        begin
            scan_next = entry_reg;
        end
        else if (ctrl.scan_shift)
        begin
            scan_next = scan_in;
        end
        else
        begin
            scan_next = scan_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        scan_reg  <= scan_next;
    end

    assign entry    = entry_reg;
    assign scan_out = scan_reg;

endmodule

### rtl/cursor_array_list_engine.sv
// Bounded list of up to DEPTH entries with a cursor, built as a row of cells that each hold one
// entry. Clear, insert, append, cursor moves and unknown commands need no scan, and a new
// command is taken in every cycle while results are taken. Read, remove and swap load the
// stored entries into a scan chain, where they travel one cell per cycle toward cell 0 until
// the entry at the cursor, or for swap the entry at the larger position, has passed. A read,
// remove or swap that is ignored still loads the scan chain. Entries are undefined after
// reset; count and cursor are zero and capacity_limit is 16. Write capacity_limit only while
// no command is in flight.
module cursor_array_list_engine #(
    parameter int DEPTH      = cale_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cale_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [cale_pkg::CMD_W-1:0]          command,
    input  logic signed [cale_pkg::VAL_W-1:0]   item_value,
    input  logic [cale_pkg::POS_W-1:0]          position,
    input  logic [cale_pkg::POS_W-1:0]          other_position,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [cale_pkg::VAL_W-1:0]   read_value,
    output logic                                value_valid,
    output logic                                status,
    output logic [cale_pkg::POS_W-1:0]          entry_count,
    output logic [cale_pkg::POS_W-1:0]          cursor_pos,
    output logic                                list_full,
    output logic                                list_empty,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cale_pkg::POS_W-1:0]          cfg_data
);

    localparam int SW = (DATA_WIDTH < cale_pkg::VAL_W) ? DATA_WIDTH : cale_pkg::VAL_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(DEPTH);
    localparam int XW = (CW > cale_pkg::POS_W) ? CW : cale_pkg::POS_W;

    cale_pkg::state_t state_reg;
    cale_pkg::state_t state_next;

    logic [cale_pkg::CMD_W-1:0] cmd_reg;
    logic [cale_pkg::CMD_W-1:0] cmd_next;
    logic [SW-1:0]              item_reg;
    logic [SW-1:0]              item_next;
    logic [cale_pkg::POS_W-1:0] p1_reg;
    logic [cale_pkg::POS_W-1:0] p1_next;
    logic [cale_pkg::POS_W-1:0] p2_reg;
    logic [cale_pkg::POS_W-1:0] p2_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              cursor_reg;
    logic [CW-1:0]              cursor_next;
    logic [cale_pkg::POS_W-1:0] cap_reg;
    logic [cale_pkg::POS_W-1:0] cap_next;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              k_next;
    logic [SW-1:0]              va_reg;
    logic [SW-1:0]              va_next;
    logic [SW-1:0]              vb_reg;
    logic [SW-1:0]              vb_next;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic [cale_pkg::VAL_W-1:0] rsp_value_reg;
    logic [cale_pkg::VAL_W-1:0] rsp_value_next;
    logic                       rsp_vv_reg;
    logic                       rsp_vv_next;
    logic                       rsp_status_reg;
    logic                       rsp_status_next;
    logic [cale_pkg::POS_W-1:0] rsp_count_reg;
    logic [cale_pkg::POS_W-1:0] rsp_count_next;
    logic [cale_pkg::POS_W-1:0] rsp_cursor_reg;
    logic [cale_pkg::POS_W-1:0] rsp_cursor_next;
    logic                       rsp_full_reg;
    logic                       rsp_full_next;
    logic                       rsp_empty_reg;
    logic                       rsp_empty_next;

    logic          cmd_acc;
    logic          commit;
    logic          scan_load;
    logic          scan_shift;
    logic          new_needs_scan;
    logic          scan_go;
    logic          scan_done;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cur_x;
    logic [XW-1:0] p1_x;
    logic [XW-1:0] p2_x;
    logic [XW-1:0] k_x;
    logic [XW-1:0] a_idx;
    logic [XW-1:0] last_x;
    logic [XW-1:0] eff_cap;
    logic          full_now;

    logic          hit_insert;
    logic          hit_append;
    logic          hit_remove;
    logic          hit_swap;
    logic          do_insert;
    logic          do_append;
    logic          do_remove;
    logic          do_swap;
    logic [CW-1:0] res_count;
    logic [CW-1:0] res_cursor;
    logic          res_valid;
    logic          res_ignored;

    logic [SW-1:0] entry_w [DEPTH];
    logic [SW-1:0] scan_w  [DEPTH];

    assign cnt_x   = XW'(count_reg);
    assign cur_x   = XW'(cursor_reg);
    assign p1_x    = XW'(p1_reg);
    assign p2_x    = XW'(p2_reg);
    assign k_x     = XW'(k_reg);
    assign eff_cap = (XW'(cap_reg) < XW'(DEPTH)) ? XW'(cap_reg) : XW'(DEPTH);
    assign full_now = (cnt_x >= eff_cap);

    assign a_idx  = (cmd_reg == cale_pkg::CMD_SWAP) ? p1_x : cur_x;
    assign last_x = (cmd_reg == cale_pkg::CMD_SWAP) ? ((p1_x > p2_x) ? p1_x : p2_x) : cur_x;
    assign scan_done = (k_x == last_x);

    assign new_needs_scan = (command inside {cale_pkg::CMD_REMOVE, cale_pkg::CMD_SWAP,
                                             cale_pkg::CMD_READ});

    always_comb
    begin
        case (cale_pkg::cmd_t'(cmd_reg))
            cale_pkg::CMD_REMOVE: scan_go = (cur_x < cnt_x);
            cale_pkg::CMD_READ:   scan_go = (cur_x < cnt_x);
            cale_pkg::CMD_SWAP:   scan_go = (p1_x < cnt_x) && (p2_x < cnt_x);
            default:              scan_go = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cale_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = new_needs_scan ? cale_pkg::ST_LOAD : cale_pkg::ST_EXEC;
                end
            end
            cale_pkg::ST_LOAD:
            begin
                state_next = scan_go ? cale_pkg::ST_SCAN : cale_pkg::ST_EXEC;
            end
            cale_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = cale_pkg::ST_EXEC;
                end
            end
            cale_pkg::ST_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (cmd_valid)
                    begin
                        state_next = new_needs_scan ? cale_pkg::ST_LOAD : cale_pkg::ST_EXEC;
                    end
                    else
                    begin
                        state_next = cale_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cale_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        commit     = 1'b0;
        cmd_stall  = 1'b1;
        scan_load  = 1'b0;
        scan_shift = 1'b0;
        case (state_reg)
            cale_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            cale_pkg::ST_LOAD:
            begin
                scan_load = 1'b1;
            end
            cale_pkg::ST_SCAN:
            begin
                scan_shift = 1'b1;
            end
            cale_pkg::ST_EXEC:
            begin
                commit    = !rsp_valid_reg || !rsp_stall;
                cmd_stall = rsp_valid_reg && rsp_stall;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    assign cmd_acc = cmd_valid && !cmd_stall;

    // Result of the held command against the current list state.
    always_comb
    begin
        res_count   = count_reg;
        res_cursor  = cursor_reg;
        res_valid   = 1'b0;
        res_ignored = 1'b0;
        hit_insert  = 1'b0;
        hit_append  = 1'b0;
        hit_remove  = 1'b0;
        hit_swap    = 1'b0;
        case (cale_pkg::cmd_t'(cmd_reg))
            cale_pkg::CMD_CLEAR:
            begin
                res_count  = '0;
                res_cursor = '0;
            end
            cale_pkg::CMD_INSERT:
            begin
                res_ignored = full_now;
                hit_insert  = !full_now;
                if (!full_now)
                begin
                    res_count = CW'(count_reg + 1'b1);
                end
            end
            cale_pkg::CMD_APPEND:
            begin
                res_ignored = full_now;
                hit_append  = !full_now;
                if (!full_now)
                begin
                    res_count = CW'(count_reg + 1'b1);
                end
            end
            cale_pkg::CMD_REMOVE:
            begin
                if (cur_x < cnt_x)
                begin
                    hit_remove = 1'b1;
                    res_valid  = 1'b1;
                    res_count  = CW'(count_reg - 1'b1);
                end
                else
                begin
                    res_ignored = 1'b1;
                end
            end
            cale_pkg::CMD_START:
            begin
                res_cursor = '0;
            end
            cale_pkg::CMD_END:
            begin
                res_cursor = count_reg;
            end
            cale_pkg::CMD_PREV:
            begin
                if (cursor_reg == '0)
                begin
                    res_ignored = 1'b1;
                end
                else
                begin
                    res_cursor = CW'(cursor_reg - 1'b1);
                end
            end
            cale_pkg::CMD_NEXT:
            begin
                if (cur_x < cnt_x)
                begin
                    res_cursor = CW'(cursor_reg + 1'b1);
                end
                else
                begin
                    res_ignored = 1'b1;
                end
            end
            cale_pkg::CMD_MOVE:
            begin
                if (p1_x > cnt_x)
                begin
                    res_ignored = 1'b1;
                end
                else
                begin
                    res_cursor = CW'(p1_reg);
                end
            end
            cale_pkg::CMD_SWAP:
            begin
                if ((p1_x < cnt_x) && (p2_x < cnt_x))
                begin
                    hit_swap = 1'b1;
                end
                else
                begin
                    res_ignored = 1'b1;
                end
            end
            cale_pkg::CMD_READ:
            begin
                if (cur_x < cnt_x)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    res_ignored = 1'b1;
                end
            end
            default:
            begin
                res_ignored = 1'b1;
            end
        endcase
    end

    assign do_insert = commit && hit_insert;
    assign do_append = commit && hit_append;
    assign do_remove = commit && hit_remove;
    assign do_swap   = commit && hit_swap;

    always_comb
    begin
        cmd_next  = cmd_acc ? command : cmd_reg;
        item_next = cmd_acc ? item_value[SW-1:0] : item_reg;
        p1_next   = cmd_acc ? position : p1_reg;
        p2_next   = cmd_acc ? other_position : p2_reg;

        count_next  = commit ? res_count : count_reg;
        cursor_next = commit ? res_cursor : cursor_reg;
        cap_next    = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

        if (scan_load)
        begin
            k_next = '0;
        end
        else if (scan_shift)
        begin
            k_next = KW'(k_reg + 1'b1);
        end
        else
        begin
            k_next = k_reg;
        end

        va_next = (scan_shift && (k_x == a_idx)) ? scan_w[0] : va_reg;
        vb_next = (scan_shift && (k_x == p2_x)) ? scan_w[0] : vb_reg;

        rsp_valid_next  = commit || (rsp_valid_reg && rsp_stall);
        rsp_value_next  = commit ? (res_valid ? cale_pkg::VAL_W'(va_reg) : '0) : rsp_value_reg;
        rsp_vv_next     = commit ? res_valid : rsp_vv_reg;
        rsp_status_next = commit ? res_ignored : rsp_status_reg;
        rsp_count_next  = commit ? cale_pkg::POS_W'(res_count) : rsp_count_reg;
        rsp_cursor_next = commit ? cale_pkg::POS_W'(res_cursor) : rsp_cursor_reg;
        rsp_full_next   = commit ? (XW'(res_count) >= eff_cap) : rsp_full_reg;
        rsp_empty_next  = commit ? (res_count == '0) : rsp_empty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cale_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            cap_reg       <= cale_pkg::CAP_RESET;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            cap_reg       <= cap_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_vv_reg     <= rsp_vv_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_cursor_reg <= rsp_cursor_next;
        rsp_full_reg   <= rsp_full_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [XW-1:0] IDX = XW'(i);

        cale_pkg::cell_ctrl_t ctrl;
        logic [SW-1:0]        left_val;
        logic [SW-1:0]        right_val;
        logic [SW-1:0]        scan_in;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid
            assign left_val = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
            assign scan_in   = '0;
        end
        else
        begin : g_inner
            assign right_val = entry_w[i+1];
            assign scan_in   = scan_w[i+1];
        end

        always_comb
        begin
            ctrl.scan_load  = scan_load;
            ctrl.scan_shift = scan_shift;
            if (do_insert && (IDX > cur_x))
            begin
                ctrl.op = cale_pkg::CELL_LEFT;
            end
            else if (do_insert && (IDX == cur_x))
            begin
                ctrl.op = cale_pkg::CELL_ITEM;
            end
            else if (do_append && (IDX == cnt_x))
            begin
                ctrl.op = cale_pkg::CELL_ITEM;
            end
            else if (do_remove && (IDX >= cur_x))
            begin
                ctrl.op = cale_pkg::CELL_RIGHT;
            end
            else if (do_swap && (IDX == p1_x))
            begin
                ctrl.op = cale_pkg::CELL_SWAP_B;
            end
            else if (do_swap && (IDX == p2_x))
            begin
                ctrl.op = cale_pkg::CELL_SWAP_A;
            end
            else
            begin
                ctrl.op = cale_pkg::CELL_HOLD;
            end
        end

        cale_cell #(
            .W (SW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .item      (item_reg),
            .swap_a    (va_reg),
            .swap_b    (vb_reg),
            .left_val  (left_val),
            .right_val (right_val),
            .scan_in   (scan_in),
            .entry     (entry_w[i]),
            .scan_out  (scan_w[i])
        );
    end

    assign cfg_ready   = 1'b1;
    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = rsp_value_reg;
    assign value_valid = rsp_vv_reg;
    assign status      = rsp_status_reg;
    assign entry_count = rsp_count_reg;
    assign cursor_pos  = rsp_cursor_reg;
    assign list_full   = rsp_full_reg;
    assign list_empty  = rsp_empty_reg;

endmodule

### rtl/cale_chk.sv
module cale_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input logic signed [cale_pkg::VAL_W-1:0]   read_value,
    input logic                                value_valid,
    input logic                                status,
    input logic [cale_pkg::POS_W-1:0]          entry_count,
    input logic [cale_pkg::POS_W-1:0]          cursor_pos,
    input logic                                list_full,
    input logic                                list_empty
);

    // A result held under stall keeps its whole payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(value_valid)
                                   && $stable(status) && $stable(entry_count)
                                   && $stable(cursor_pos) && $stable(list_full)
                                   && $stable(list_empty))
        else $error("result changed while stalled");

    // The cursor never passes the end of the list.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cursor_pos <= entry_count)
        else $error("cursor beyond entry count");

    // A returned value always comes from a command that was carried out.
    a_value_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && value_valid |-> !status)
        else $error("value returned by an ignored command");

    // A command that returns nothing reports a zero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !value_valid |-> read_value == '0)
        else $error("nonzero value without a valid entry");

    // An empty list reports no entries.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && list_empty |-> entry_count == '0)
        else $error("empty flag with a nonzero entry count");

endmodule

bind cursor_array_list_engine cale_chk u_cale_chk (.*);

### bench/cale_list_checker.sv
module cale_list_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_stall,
    input  logic [cale_pkg::CMD_W-1:0]        command,
    input  logic signed [cale_pkg::VAL_W-1:0] item_value,
    input  logic [cale_pkg::POS_W-1:0]        position,
    input  logic [cale_pkg::POS_W-1:0]        other_position,
    input  logic                              rsp_valid,
    input  logic                              rsp_stall,
    input  logic signed [cale_pkg::VAL_W-1:0] read_value,
    input  logic                              value_valid,
    input  logic                              status,
    input  logic [cale_pkg::POS_W-1:0]        entry_count,
    input  logic [cale_pkg::POS_W-1:0]        cursor_pos,
    input  logic                              list_full,
    input  logic                              list_empty,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [cale_pkg::POS_W-1:0]        cfg_data,
    output int unsigned                       fail_count,
    output int unsigned                       result_count,
    output int unsigned                       data_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = cale_pkg::DEPTH_DEF;

    typedef struct packed {
        logic signed [cale_pkg::VAL_W-1:0] value;
        logic                              valid;
        logic                              ignored;
        logic [cale_pkg::POS_W-1:0]        count;
        logic [cale_pkg::POS_W-1:0]        cursor;
        logic                              full;
        logic                              empty;
    } list_result_t;

    logic [cale_pkg::VAL_W-1:0] slot_data [SLOTS];
    int                         fill;
    int                         cur;
    logic [cale_pkg::POS_W-1:0] cap_limit;
    list_result_t               pending_results [$];

    function automatic int room_limit();
        return (int'(cap_limit) < SLOTS) ? int'(cap_limit) : SLOTS;
    endfunction

    function automatic list_result_t list_step(input logic [cale_pkg::CMD_W-1:0] cmd,
                                               input logic [cale_pkg::VAL_W-1:0] val,
                                               input logic [cale_pkg::POS_W-1:0] p1,
                                               input logic [cale_pkg::POS_W-1:0] p2);
        list_result_t               res;
        logic                       was_full;
        logic [cale_pkg::VAL_W-1:0] tmp;
        res      = '0;
        was_full = (fill >= room_limit());
        case (cmd)
            cale_pkg::CMD_CLEAR:
            begin
                fill = 0;
                cur  = 0;
            end
            cale_pkg::CMD_INSERT:
            begin
                if (was_full)
                    res.ignored = 1'b1;
                else
                begin
                    for (int i = fill; i > cur; i--)
                        slot_data[i] = slot_data[i-1];
                    slot_data[cur] = val;
                    fill++;
                end
            end
            cale_pkg::CMD_APPEND:
            begin
                if (was_full)
                    res.ignored = 1'b1;
                else
                begin
                    slot_data[fill] = val;
                    fill++;
                end
            end
            cale_pkg::CMD_REMOVE:
            begin
                if (cur >= fill)
                    res.ignored = 1'b1;
                else
                begin
                    res.value = slot_data[cur];
                    res.valid = 1'b1;
                    for (int i = cur; i + 1 < fill; i++)
                        slot_data[i] = slot_data[i+1];
                    fill--;
                end
            end
            cale_pkg::CMD_START:
                cur = 0;
            cale_pkg::CMD_END:
                cur = fill;
            cale_pkg::CMD_PREV:
            begin
                if (cur == 0)
                    res.ignored = 1'b1;
                else
                    cur--;
            end
            cale_pkg::CMD_NEXT:
            begin
                if (cur >= fill)
                    res.ignored = 1'b1;
                else
                    cur++;
            end
            cale_pkg::CMD_MOVE:
            begin
                if (int'(p1) > fill)
                    res.ignored = 1'b1;
                else
                    cur = int'(p1);
            end
            cale_pkg::CMD_SWAP:
            begin
                if (int'(p1) >= fill || int'(p2) >= fill)
                    res.ignored = 1'b1;
                else
                begin
                    tmp           = slot_data[p1];
                    slot_data[p1] = slot_data[p2];
                    slot_data[p2] = tmp;
                end
            end
            cale_pkg::CMD_READ:
            begin
                if (cur >= fill)
                    res.ignored = 1'b1;
                else
                begin
                    res.value = slot_data[cur];
                    res.valid = 1'b1;
                end
            end
            default:
                res.ignored = 1'b1;
        endcase
        res.count  = cale_pkg::POS_W'(fill);
        res.cursor = cale_pkg::POS_W'(cur);
        res.full   = (fill >= room_limit());
        res.empty  = (fill == 0);
        return res;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got,
                                 inout int errs);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        int           errs;
        if (!rst_n)
        begin
            fill      = 0;
            cur       = 0;
            cap_limit = cale_pkg::CAP_RESET;
            pending_results.delete();
            fail_count   <= 0;
            result_count <= 0;
            data_count   <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                result_count <= result_count + 1;
                if (pending_results.size() == 0)
                begin
                    $error("Result transfer arrived with no command outstanding.");
                    errs++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.valid)
                        data_count <= data_count + 1;
                    compare_field("read_value", want.value, read_value, errs);
                    compare_field("value_valid", want.valid, value_valid, errs);
                    compare_field("status", want.ignored, status, errs);
                    compare_field("entry_count", want.count, entry_count, errs);
                    compare_field("cursor_pos", want.cursor, cursor_pos, errs);
                    compare_field("list_full", want.full, list_full, errs);
                    compare_field("list_empty", want.empty, list_empty, errs);
                end
            end
            if (cmd_valid && !cmd_stall)
                pending_results.push_back(list_step(command, item_value, position,
                                                    other_position));
            fail_count <= fail_count + errs;
        end
    end

endmodule

### bench/cursor_array_list_engine_test.sv
module cursor_array_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cale_pkg::CMD_W-1:0] CMD_BAD_FIRST = 4'd11;
    localparam logic [cale_pkg::CMD_W-1:0] CMD_BAD_LAST  = 4'd15;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                              clk;
    logic                              rst_n;
    logic                              cmd_valid;
    logic                              cmd_stall;
    logic [cale_pkg::CMD_W-1:0]        command;
    logic signed [cale_pkg::VAL_W-1:0] item_value;
    logic [cale_pkg::POS_W-1:0]        position;
    logic [cale_pkg::POS_W-1:0]        other_position;
    logic                              rsp_valid;
    logic                              rsp_stall;
    logic signed [cale_pkg::VAL_W-1:0] read_value;
    logic                              value_valid;
    logic                              status;
    logic [cale_pkg::POS_W-1:0]        entry_count;
    logic [cale_pkg::POS_W-1:0]        cursor_pos;
    logic                              list_full;
    logic                              list_empty;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [cale_pkg::POS_W-1:0]        cfg_data;

    int unsigned fail_count;
    int unsigned result_count;
    int unsigned data_count;
    int unsigned sent;
    int unsigned cycles = 0;
    int unsigned cap_writes;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_token;
    int          hold_done;

    cursor_array_list_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .item_value     (item_value),
        .position       (position),
        .other_position (other_position),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .read_value     (read_value),
        .value_valid    (value_valid),
        .status         (status),
        .entry_count    (entry_count),
        .cursor_pos     (cursor_pos),
        .list_full      (list_full),
        .list_empty     (list_empty),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    cale_list_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .item_value     (item_value),
        .position       (position),
        .other_position (other_position),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .read_value     (read_value),
        .value_valid    (value_valid),
        .status         (status),
        .entry_count    (entry_count),
        .cursor_pos     (cursor_pos),
        .list_full      (list_full),
        .list_empty     (list_empty),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .result_count   (result_count),
        .data_count     (data_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random, and serves a long hold-off whenever one is requested.
    initial
    begin
        rsp_stall <= 1'b0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_done)
            begin
                hold_done = hold_token;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_cmd(input logic [cale_pkg::CMD_W-1:0] cmd,
                            input logic [cale_pkg::VAL_W-1:0] val,
                            input logic [cale_pkg::POS_W-1:0] p1,
                            input logic [cale_pkg::POS_W-1:0] p2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        command        <= cmd;
        item_value     <= val;
        position       <= p1;
        other_position <= p2;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_results();
        cmd_valid <= 1'b0;
        while (result_count != sent)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [cale_pkg::POS_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [cale_pkg::CMD_W-1:0] pick_cmd(input bit growing);
        int r;
        int s;
        r = $urandom_range(99);
        s = $urandom_range(99);
        if (r < 2)
            return cale_pkg::CMD_CLEAR;
        if (r < 5)
            return cale_pkg::CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        if (r < 50)
        begin
            if (s < (growing ? 45 : 15))
                return cale_pkg::CMD_INSERT;
            if (s < (growing ? 80 : 30))
                return cale_pkg::CMD_APPEND;
            return cale_pkg::CMD_REMOVE;
        end
        if (r < 54)
            return cale_pkg::CMD_START;
        if (r < 58)
            return cale_pkg::CMD_END;
        if (r < 65)
            return cale_pkg::CMD_PREV;
        if (r < 73)
            return cale_pkg::CMD_NEXT;
        if (r < 81)
            return cale_pkg::CMD_MOVE;
        if (r < 89)
            return cale_pkg::CMD_SWAP;
        return cale_pkg::CMD_READ;
    endfunction

    function automatic logic [cale_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [cale_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(4) == 0)
            return cale_pkg::POS_W'($urandom_range(31));
        return cale_pkg::POS_W'($urandom_range(16));
    endfunction

    initial
    begin : stimulus
        int  cap_plan [PHASES];
        int  send_plan [4];
        int  stall_plan [4];
        bit  growing;
        cap_plan   = '{16, 1, 5, 0, 16, 31, -1, 3};
        send_plan  = '{0, 88, 0, 34};
        stall_plan = '{0, 0, 88, 34};
        rst_n          <= 1'b0;
        cmd_valid      <= 1'b0;
        command        <= cale_pkg::CMD_CLEAR;
        item_value     <= '0;
        position       <= '0;
        other_position <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_token     = 0;
        sent           = 0;
        cap_writes     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-list corner cases first, then edges of the cursor and the stored values.
        push_cmd(cale_pkg::CMD_READ, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_REMOVE, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_PREV, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_NEXT, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_MOVE, 32'h0, 5'd1, 5'd0);
        push_cmd(cale_pkg::CMD_SWAP, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_APPEND, 32'h7FFF_FFFF, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_APPEND, 32'h8000_0000, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_INSERT, 32'h0000_0000, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_END, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_READ, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_REMOVE, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_NEXT, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_PREV, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_READ, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_REMOVE, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_START, 32'h0, 5'd0, 5'd0);
        push_cmd(cale_pkg::CMD_MOVE, 32'h0, 5'd3, 5'd0);
        push_cmd(cale_pkg::CMD_MOVE, 32'h0, 5'd31, 5'd16);
        push_cmd(cale_pkg::CMD_SWAP, 32'h0, 5'd0, 5'd2);
        push_cmd(cale_pkg::CMD_SWAP, 32'h0, 5'd16, 5'd31);
        push_cmd(cale_pkg::CMD_READ, 32'h0, 5'd0, 5'd0);
        push_cmd(CMD_BAD_FIRST, 32'h0, 5'd0, 5'd0);
        push_cmd(CMD_BAD_LAST, 32'hFFFF_FFFF, 5'd31, 5'd31);
        push_cmd(cale_pkg::CMD_CLEAR, 32'h0, 5'd0, 5'd0);
        wait_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (cap_plan[ph] < 0)
                write_capacity(cale_pkg::POS_W'($urandom_range(1, 16)));
            else
                write_capacity(cale_pkg::POS_W'(cap_plan[ph]));
            send_idle_pct = send_plan[ph % 4];
            stall_pct     = stall_plan[ph % 4];
            growing       = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    growing = $urandom_range(1);
                if (n == 50 && send_idle_pct == 0)
                    hold_token++;
                if (n == PHASE_ITEMS / 2)
                    wait_results();
                push_cmd(pick_cmd(growing), pick_value(), pick_position(), pick_position());
            end
            wait_results();
        end

        repeat (24) @(posedge clk);
        $display("Ran %0d list commands over %0d capacity settings and four traffic profiles.",
                 sent, cap_writes + 1);
        $display("Checked %0d results, %0d of which returned a stored entry.",
                 result_count, data_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### cursor_array_list_engine.f
rtl/cale_pkg.sv
rtl/cale_cell.sv
rtl/cursor_array_list_engine.sv
rtl/cale_chk.sv
bench/cale_list_checker.sv
bench/cursor_array_list_engine_test.sv
